// ----- sv/gcc_pkg.sv -----
// Shared types, constants and helpers of the gradient coverage compositor.
`default_nettype none
package gcc_pkg;

	// Field widths fixed by the pixel and register formats.
	localparam int COORD_W    = 14;
	localparam int COV_W      = 8;
	localparam int PIX_W      = 32;
	localparam int CH_W       = 8;
	localparam int COLOR_W    = 24;
	localparam int DIM_REG_W  = 13;
	localparam int CNT_REG_W  = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam int ALPHA_LSB  = 24;

	// Defaults for the top-level parameters.
	localparam int DEF_COLOR_SLOTS = 5;
	localparam int DEF_MAX_DIM     = 4096;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BUF_WIDTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BUF_HEIGHT  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR0      = CFG_IDX_W'(3);

	// Reset contents of the configuration registers.
	localparam logic [DIM_REG_W-1:0] DIM_RESET    = DIM_REG_W'(1);
	localparam logic [CNT_REG_W-1:0] COUNT_RESET  = CNT_REG_W'(1);
	localparam logic [COLOR_W-1:0]   COLOR0_RESET = 24'hFFFFFF;

	// Pipeline stages outside the two divider chains.
	localparam int PIPE_FIXED = 6;

	// Sideband that travels with every pixel through the pipeline.
	typedef struct packed {
		logic                 wr;
		logic [COV_W-1:0]     cov;
		logic [PIX_W-1:0]     dest;
	} gcc_side_t;

	// Number of quotient bits of the gradient segment index.
	function automatic int seg_steps(input int slots);
		return (slots > 2) ? $clog2(slots - 1) : 1;
	endfunction

	// Total latency from an accepted pixel to its result strobe.
	function automatic int pipe_latency(input int slots);
		return seg_steps(slots) + CH_W + PIPE_FIXED;
	endfunction

	// Exact floor(x / 255) for any product of two 8-bit values.
	function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
		logic [2*CH_W:0] t;
		t = (2*CH_W+1)'(x) + (2*CH_W+1)'(x >> CH_W) + (2*CH_W+1)'(1);
		return t[2*CH_W-1:CH_W];
	endfunction

endpackage
`default_nettype wire

// ----- sv/gcc_div_cell.sv -----
// One restoring division step for several lanes that share a divisor.
`default_nettype none
module gcc_div_cell #(
	parameter int LANES = 1,
	parameter int REM_W = 13,
	parameter int STEPS = 8,
	parameter int PAY_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [LANES-1:0][REM_W-1:0]       in_rem,
	input  logic [LANES-1:0][STEPS-1:0]       in_lo,
	input  logic [LANES-1:0][STEPS-1:0]       in_quo,
	input  logic [PAY_W-1:0]                  in_pay,
	input  logic [REM_W-1:0]                  divisor,
	output logic                              out_valid,
	output logic [LANES-1:0][REM_W-1:0]       out_rem,
	output logic [LANES-1:0][STEPS-1:0]       out_lo,
	output logic [LANES-1:0][STEPS-1:0]       out_quo,
	output logic [PAY_W-1:0]                  out_pay
);

	logic [LANES-1:0][REM_W:0]   trial;
	logic [LANES-1:0][REM_W:0]   diff;
	logic [LANES-1:0]            take;
	logic [LANES-1:0][REM_W-1:0] rem_d;
	logic [LANES-1:0][STEPS-1:0] lo_d;
	logic [LANES-1:0][STEPS-1:0] quo_d;

	logic                        valid_q;
	logic [LANES-1:0][REM_W-1:0] rem_q;
	logic [LANES-1:0][STEPS-1:0] lo_q;
	logic [LANES-1:0][STEPS-1:0] quo_q;
	logic [PAY_W-1:0]            pay_q;

	// Bring down the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {in_rem[l], in_lo[l][STEPS-1]};
			diff[l]  = trial[l] - {1'b0, divisor};
			take[l]  = (trial[l] >= {1'b0, divisor});
			rem_d[l] = take[l] ? diff[l][REM_W-1:0] : trial[l][REM_W-1:0];
			lo_d[l]  = in_lo[l] << 1;
			quo_d[l] = (in_quo[l] << 1) | STEPS'(take[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		lo_q  <= lo_d;
		quo_q <= quo_d;
		pay_q <= in_pay;
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_lo    = lo_q;
	assign out_quo   = quo_q;
	assign out_pay   = pay_q;

endmodule
`default_nettype wire

// ----- sv/gcc_div_chain.sv -----
// A row of division cells, one quotient bit per cell, one stage per cell.
`default_nettype none
module gcc_div_chain #(
	parameter int LANES = 1,
	parameter int REM_W = 13,
	parameter int STEPS = 8,
	parameter int PAY_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [LANES-1:0][REM_W-1:0]       in_rem,
	input  logic [LANES-1:0][STEPS-1:0]       in_lo,
	input  logic [PAY_W-1:0]                  in_pay,
	input  logic [REM_W-1:0]                  divisor,
	output logic                              out_valid,
	output logic [LANES-1:0][REM_W-1:0]       out_rem,
	output logic [LANES-1:0][STEPS-1:0]       out_quo,
	output logic [PAY_W-1:0]                  out_pay
);

	logic [STEPS:0]                           valid_c;
	logic [STEPS:0][LANES-1:0][REM_W-1:0]     rem_c;
	logic [STEPS:0][LANES-1:0][STEPS-1:0]     lo_c;
	logic [STEPS:0][LANES-1:0][STEPS-1:0]     quo_c;
	logic [STEPS:0][PAY_W-1:0]                pay_c;

	assign valid_c[0] = in_valid;
	assign rem_c[0]   = in_rem;
	assign lo_c[0]    = in_lo;
	assign quo_c[0]   = '0;
	assign pay_c[0]   = in_pay;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		gcc_div_cell #(
			.LANES (LANES),
			.REM_W (REM_W),
			.STEPS (STEPS),
			.PAY_W (PAY_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_rem    (rem_c[i]),
			.in_lo     (lo_c[i]),
			.in_quo    (quo_c[i]),
			.in_pay    (pay_c[i]),
			.divisor   (divisor),
			.out_valid (valid_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_lo    (lo_c[i+1]),
			.out_quo   (quo_c[i+1]),
			.out_pay   (pay_c[i+1])
		);
	end

	// The dividend bits are all consumed by the last cell.
	assign out_valid = valid_c[STEPS];
	assign out_rem   = rem_c[STEPS];
	assign out_quo   = quo_c[STEPS];
	assign out_pay   = pay_c[STEPS];

endmodule
`default_nettype wire

// ----- sv/gcc_color_store.sv -----
// Gradient color table with one write port and two registered read ports.
`default_nettype none
module gcc_color_store #(
	parameter  int SLOTS = gcc_pkg::DEF_COLOR_SLOTS,
	localparam int AW    = $clog2(SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [gcc_pkg::COLOR_W-1:0] wr_data,
	input  logic [AW-1:0]               rd_addr_a,
	input  logic [AW-1:0]               rd_addr_b,
	output logic [gcc_pkg::COLOR_W-1:0] rd_data_a,
	output logic [gcc_pkg::COLOR_W-1:0] rd_data_b
);
	import gcc_pkg::*;

	logic [COLOR_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]   written_q;
	logic [COLOR_W-1:0] rst_a;
	logic [COLOR_W-1:0] rst_b;
	logic [COLOR_W-1:0] rd_a_q;
	logic [COLOR_W-1:0] rd_b_q;

	// An entry never written reads as its reset color.
	assign rst_a = (rd_addr_a == '0) ? COLOR0_RESET : '0;
	assign rst_b = (rd_addr_b == '0) ? COLOR0_RESET : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= written_q[rd_addr_a] ? mem[rd_addr_a] : rst_a;
		rd_b_q <= written_q[rd_addr_b] ? mem[rd_addr_b] : rst_b;
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule
`default_nettype wire

// ----- sv/gradient_coverage_composite.sv -----
// Top level of the gradient coverage compositor: clip, gradient, blend, pack.
//
//  Channel   Signals                                          Handshake
//  --------  -----------------------------------------------  ---------------------------
//  command   start, busy, pixel_x, pixel_y, coverage,         taken when start && !busy
//            dest_pixel
//  result    done, write_enable, new_pixel                    one cycle, marked by done
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data        taken when both are high
//
// The block is a fixed pipeline: one pixel is taken every clock cycle and its
// result passes through two rows of division cells, one quotient bit per cell:
// the gradient segment divide and the per-channel blend divide by the buffer
// width (eight cells), plus six plain stages around them. busy never rises,
// since every stage advances in every cycle, and the result side cannot stall.
// Reset clears the stage valid bits and the written marks of the color table
// and sets the size and count registers to one; payload registers are not
// reset. Configuration transactions are always taken and must only be issued
// while no pixel is in flight.
`default_nettype none
module gradient_coverage_composite #(
	parameter int COLOR_SLOTS = gcc_pkg::DEF_COLOR_SLOTS,
	parameter int MAX_DIM     = gcc_pkg::DEF_MAX_DIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [gcc_pkg::COORD_W-1:0] pixel_x,
	input  logic signed [gcc_pkg::COORD_W-1:0] pixel_y,
	input  logic [gcc_pkg::COV_W-1:0]      coverage,
	input  logic [gcc_pkg::PIX_W-1:0]      dest_pixel,
	output logic                          done,
	output logic                          write_enable,
	output logic [gcc_pkg::PIX_W-1:0]      new_pixel,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gcc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gcc_pkg::*;

	// Width of a saturated buffer dimension, of an inside coordinate, of the
	// clamped color count, of a color table index and of the gradient position.
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int XW    = $clog2(MAX_DIM);
	localparam int NW    = $clog2(COLOR_SLOTS + 1);
	localparam int CIW   = $clog2(COLOR_SLOTS);
	localparam int QW    = seg_steps(COLOR_SLOTS);
	localparam int PW    = XW + NW;
	localparam int MW    = CH_W + DW;
	localparam int CMP_W = (DW > COORD_W - 1) ? DW : COORD_W - 1;
	localparam int SIDE_W = $bits(gcc_side_t);

	// ---------------------------------------------------------------------
	// Configuration registers. The color table lives in its own store.
	// ---------------------------------------------------------------------
	logic [DIM_REG_W-1:0] width_q;
	logic [DIM_REG_W-1:0] height_q;
	logic [CNT_REG_W-1:0] count_q;
	logic                 cfg_we;
	logic                 color_we;
	logic [CFG_IDX_W-1:0] color_off;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign color_off = cfg_index - REG_COLOR0;
	assign color_we  = cfg_we && (cfg_index >= REG_COLOR0) &&
		(32'(cfg_index) < 32'(REG_COLOR0) + COLOR_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			count_q  <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUF_WIDTH:   width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_BUF_HEIGHT:  height_q <= cfg_data[DIM_REG_W-1:0];
				REG_COLOR_COUNT: count_q  <= cfg_data[CNT_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes above the supported maximum saturate; a color count of zero acts
	// as one and a count above the slot number is cut to the slot number.
	logic [DW-1:0] w_eff;
	logic [DW-1:0] h_eff;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] n_minus1;

	assign w_eff = (32'(width_q) > MAX_DIM)  ? DW'(MAX_DIM) : DW'(width_q);
	assign h_eff = (32'(height_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(height_q);

	always_comb begin
		if (count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(count_q) > COLOR_SLOTS) begin
			n_eff = NW'(COLOR_SLOTS);
		end else begin
			n_eff = NW'(count_q);
		end
		n_minus1 = n_eff - NW'(1);
	end

	// ---------------------------------------------------------------------
	// Stage 1: clipping, write decision and the gradient position x*(n-1).
	// A pixel that is not written still flows through so that its result
	// keeps its place; it then carries the destination pixel unchanged.
	// ---------------------------------------------------------------------
	logic             accept;
	logic             in_buf;
	logic             wr_d;
	logic [XW-1:0]    x_in;
	logic [PW-1:0]    pos_d;

	assign accept = start && !busy;
	assign in_buf = !pixel_x[COORD_W-1] && !pixel_y[COORD_W-1] &&
		(CMP_W'(pixel_x[COORD_W-2:0]) < CMP_W'(w_eff)) &&
		(CMP_W'(pixel_y[COORD_W-2:0]) < CMP_W'(h_eff));
	assign wr_d   = in_buf && (coverage != '0) &&
		(coverage > dest_pixel[PIX_W-1:ALPHA_LSB]);
	// Only the low bits matter: an inside column lies below MAX_DIM.
	assign x_in   = pixel_x[XW-1:0];
	assign pos_d  = PW'(x_in) * PW'(n_minus1);

	logic          v_s1;
	gcc_side_t     side_s1;
	logic [PW-1:0] pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.wr   <= wr_d;
		side_s1.cov  <= coverage;
		side_s1.dest <= dest_pixel;
		pos_s1       <= pos_d;
	end

	// ---------------------------------------------------------------------
	// Segment divide: q = pos / width, r = pos % width. The position is below
	// width * (n - 1), so q has QW bits and the upper part of the position is
	// already below the width when it enters the first cell.
	// ---------------------------------------------------------------------
	logic [0:0][DW-1:0] seg_rem_in;
	logic [0:0][QW-1:0] seg_lo_in;
	logic               seg_v;
	logic [0:0][DW-1:0] seg_rem;
	logic [0:0][QW-1:0] seg_quo;
	logic [SIDE_W-1:0]  seg_pay;

	assign seg_rem_in[0] = DW'(pos_s1 >> QW);
	assign seg_lo_in[0]  = pos_s1[QW-1:0];

	gcc_div_chain #(
		.LANES (1),
		.REM_W (DW),
		.STEPS (QW),
		.PAY_W (SIDE_W)
	) u_seg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_rem    (seg_rem_in),
		.in_lo     (seg_lo_in),
		.in_pay    (side_s1),
		.divisor   (w_eff),
		.out_valid (seg_v),
		.out_rem   (seg_rem),
		.out_quo   (seg_quo),
		.out_pay   (seg_pay)
	);

	// ---------------------------------------------------------------------
	// Stage 2: read the two end colors of the segment. With a flat color the
	// position is zero, so the first end is color 0 and the remainder is zero.
	// ---------------------------------------------------------------------
	logic [CIW-1:0]     idx_a;
	logic [CIW-1:0]     idx_b;
	logic [COLOR_W-1:0] col_a_s2;
	logic [COLOR_W-1:0] col_b_s2;

	assign idx_a = CIW'(seg_quo[0]);
	assign idx_b = idx_a + CIW'(1);

	gcc_color_store #(
		.SLOTS (COLOR_SLOTS)
	) u_colors (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (color_we),
		.wr_addr   (color_off[CIW-1:0]),
		.wr_data   (cfg_data[COLOR_W-1:0]),
		.rd_addr_a (idx_a),
		.rd_addr_b (idx_b),
		.rd_data_a (col_a_s2),
		.rd_data_b (col_b_s2)
	);

	logic          v_s2;
	gcc_side_t     side_s2;
	logic [DW-1:0] rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= seg_v;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= seg_pay;
		rem_s2  <= seg_rem[0];
	end

	// ---------------------------------------------------------------------
	// Stage 3: weights of the two end colors, c[q]*(W-r) and c[q+1]*r.
	// Channel 0 is red (bits 7..0), channel 1 green, channel 2 blue.
	// ---------------------------------------------------------------------
	logic [DW-1:0]          w_minus_r;
	logic                   v_s3;
	gcc_side_t              side_s3;
	logic [2:0][MW-1:0]     prod_a_s3;
	logic [2:0][MW-1:0]     prod_b_s3;

	assign w_minus_r = w_eff - rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		for (int k = 0; k < 3; k++) begin
			prod_a_s3[k] <= MW'(col_a_s2[CH_W*k +: CH_W]) * MW'(w_minus_r);
			prod_b_s3[k] <= MW'(col_b_s2[CH_W*k +: CH_W]) * MW'(rem_s2);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: blend numerator. It never exceeds 255 * width.
	// ---------------------------------------------------------------------
	logic               v_s4;
	gcc_side_t          side_s4;
	logic [2:0][MW-1:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		for (int k = 0; k < 3; k++) begin
			sum_s4[k] <= prod_a_s3[k] + prod_b_s3[k];
		end
	end

	// ---------------------------------------------------------------------
	// Channel divide by the width, three lanes side by side. The quotient
	// is a channel value, so eight cells suffice.
	// ---------------------------------------------------------------------
	logic [2:0][DW-1:0]   ch_rem_in;
	logic [2:0][CH_W-1:0] ch_lo_in;
	logic                 ch_v;
	logic [2:0][DW-1:0]   ch_rem;
	logic [2:0][CH_W-1:0] ch_quo;
	logic [SIDE_W-1:0]    ch_pay;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ch_rem_in[k] = DW'(sum_s4[k] >> CH_W);
			ch_lo_in[k]  = sum_s4[k][CH_W-1:0];
		end
	end

	gcc_div_chain #(
		.LANES (3),
		.REM_W (DW),
		.STEPS (CH_W),
		.PAY_W (SIDE_W)
	) u_ch_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_rem    (ch_rem_in),
		.in_lo     (ch_lo_in),
		.in_pay    (side_s4),
		.divisor   (w_eff),
		.out_valid (ch_v),
		.out_rem   (ch_rem),
		.out_quo   (ch_quo),
		.out_pay   (ch_pay)
	);

	// The final remainders of the blend divide are not needed.
	logic ch_rem_unused;
	assign ch_rem_unused = ^ch_rem;

	// ---------------------------------------------------------------------
	// Stage 5: premultiply each channel by the coverage.
	// ---------------------------------------------------------------------
	logic                   v_s5;
	gcc_side_t              side_s5;
	gcc_side_t              ch_side;
	logic [2:0][2*CH_W-1:0] pm_s5;

	assign ch_side = ch_pay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= ch_v && !ch_rem_unused | ch_v;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= ch_side;
		for (int k = 0; k < 3; k++) begin
			pm_s5[k] <= (2*CH_W)'(ch_quo[k]) * (2*CH_W)'(ch_side.cov);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: scale by 1/255 and pack as A, R, G, B. A pixel that is not
	// written returns the destination pixel as it came in.
	// ---------------------------------------------------------------------
	logic [PIX_W-1:0] packed_pix;
	logic             done_q;
	logic             we_q;
	logic [PIX_W-1:0] pix_q;

	assign packed_pix = {side_s5.cov, div255(pm_s5[0]), div255(pm_s5[1]), div255(pm_s5[2])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		we_q  <= side_s5.wr;
		pix_q <= side_s5.wr ? packed_pix : side_s5.dest;
	end

	assign done         = done_q;
	assign write_enable = we_q;
	assign new_pixel    = pix_q;

endmodule
`default_nettype wire

// ----- sv/gcc_checker.sv -----
// Port-level checks of the compositor and the bind that attaches them.
`default_nettype none
module gcc_checker #(
	parameter int COLOR_SLOTS = gcc_pkg::DEF_COLOR_SLOTS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [gcc_pkg::COV_W-1:0]      coverage,
	input logic [gcc_pkg::PIX_W-1:0]      dest_pixel,
	input logic                          done,
	input logic                          write_enable,
	input logic [gcc_pkg::PIX_W-1:0]      new_pixel
);
	import gcc_pkg::*;

	localparam int LAT = pipe_latency(COLOR_SLOTS);

	// Every accepted pixel yields its result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted pixel produced no result");

	// No result appears without a pixel accepted the latency before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted pixel");

	// A skipped pixel hands back the destination pixel unchanged.
	a_skip_keeps_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !write_enable) |-> (new_pixel == $past(dest_pixel, LAT)))
		else $error("skipped pixel altered the destination");

	// A written pixel carries the coverage as alpha, above the old alpha.
	a_write_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_enable) |->
		((new_pixel[PIX_W-1:ALPHA_LSB] == $past(coverage, LAT)) &&
		($past(coverage, LAT) > $past(dest_pixel[PIX_W-1:ALPHA_LSB], LAT))))
		else $error("written pixel has a wrong alpha");

	// Premultiplied channels never exceed the alpha.
	a_premultiplied: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_enable) |->
		((new_pixel[23:16] <= new_pixel[31:24]) &&
		(new_pixel[15:8] <= new_pixel[31:24]) &&
		(new_pixel[7:0] <= new_pixel[31:24])))
		else $error("color channel above alpha");

endmodule

bind gradient_coverage_composite gcc_checker #(
	.COLOR_SLOTS (COLOR_SLOTS)
) u_gcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.coverage     (coverage),
	.dest_pixel   (dest_pixel),
	.done         (done),
	.write_enable (write_enable),
	.new_pixel    (new_pixel)
);
`default_nettype wire
